// ===== src/slc_pkg.sv =====
// Shared types and constants for the size-budget LRU cache.
// No dependencies; every other file uses it by scoped names.
package slc_pkg;

  localparam int KEY_W  = 32;
  localparam int SIZE_W = 32;
  localparam int TOT_W  = 48;
  localparam int OP_W   = 2;

  localparam int MAX_EVICT = 16;
  localparam int EVC_W     = 5;
  localparam int QDEPTH    = 2;

  localparam logic [TOT_W-1:0] BUDGET_RESET = 48'd67108864;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TRIM   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  out_key;
    logic              hit;
    logic [TOT_W-1:0]  total_bytes;
    logic              last;
  } res_t;

endpackage

// ===== src/slc_if.sv =====
// Handshake channel interfaces: request items, result items, budget writes.
// Depends on slc_pkg.
interface slc_item_if;
  logic                       valid;
  logic                       ready;
  logic [slc_pkg::OP_W-1:0]   op;
  logic [slc_pkg::KEY_W-1:0]  key;
  logic [slc_pkg::SIZE_W-1:0] item_size;
  modport source (output valid, op, key, item_size, input ready);
  modport sink   (input valid, op, key, item_size, output ready);
endinterface

interface slc_result_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [slc_pkg::KEY_W-1:0] out_key;
  logic                      hit;
  logic [slc_pkg::TOT_W-1:0] total_bytes;
  logic                      last;
  modport source (output valid, kind, out_key, hit, total_bytes, last, input ready);
  modport sink   (input valid, kind, out_key, hit, total_bytes, last, output ready);
endinterface

interface slc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [slc_pkg::TOT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/slc_front.sv =====
// Front end: accepts request items and decodes them into queue entries.
// Depends on slc_pkg and slc_if.
module slc_front (
  slc_item_if.sink        in_i,
  input  logic            q_ready_i,
  output logic            q_valid_o,
  output slc_pkg::req_t   q_req_o
);

  assign in_i.ready     = q_ready_i;
  assign q_valid_o      = in_i.valid;
  assign q_req_o.op     = slc_pkg::op_e'(in_i.op);
  assign q_req_o.key    = in_i.key;
  assign q_req_o.size   = in_i.item_size;

endmodule

// ===== src/slc_fifo.sv =====
// Short request queue between front and back end.
// Depends on slc_pkg.
module slc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  slc_pkg::req_t push_req_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output slc_pkg::req_t pop_req_o
);

  localparam int Depth = slc_pkg::QDEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  slc_pkg::req_t   mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_req_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_req_i;
  end

endmodule

// ===== src/slc_back.sv =====
// Back end: recency-ordered entry cells, search, update and eviction walk.
// Depends on slc_pkg.
module slc_back #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  slc_pkg::req_t             req_i,
  input  logic [slc_pkg::TOT_W-1:0] budget_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output slc_pkg::res_t             res_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_MOVE   = 7'b0000100,
    S_FULLEV = 7'b0001000,
    S_INSERT = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_ACK    = 7'b1000000
  } state_e;

  state_e                       state_q, state_d;
  logic [slc_pkg::KEY_W-1:0]    key_q  [ENTRIES];
  logic [slc_pkg::SIZE_W-1:0]   size_q [ENTRIES];
  logic [CW-1:0]                n_q, n_d;
  logic [slc_pkg::TOT_W-1:0]    total_q, total_d;
  slc_pkg::req_t                cur_q;
  logic                         hit_q;
  logic [IW-1:0]                pos_q;
  logic [slc_pkg::EVC_W-1:0]    evc_q;
  slc_pkg::res_t                res_q, res_d;
  logic                         res_valid_q;

  logic [ENTRIES-1:0]           match;
  logic [IW-1:0]                match_pos;
  logic [IW-1:0]                tail;
  logic                         out_free, emit, shift_en, is_move;
  logic [IW-1:0]                shift_lim;

  assign out_free    = !res_valid_q || res_ready_i;
  assign tail        = IW'(n_q - 1'b1);
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    match_pos = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      match[p] = (CW'(p) < n_q) && (key_q[p] == cur_q.key);
      if (match[p]) match_pos = IW'(p);
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    total_d   = total_q;
    emit      = 1'b0;
    shift_en  = 1'b0;
    is_move   = 1'b0;
    shift_lim = IW'(ENTRIES - 1);
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if ((|match) && (cur_q.op == slc_pkg::OP_LOOKUP || cur_q.op == slc_pkg::OP_INSERT))
          state_d = S_MOVE;
        else if (cur_q.op == slc_pkg::OP_INSERT)
          state_d = (n_q == CW'(ENTRIES)) ? S_FULLEV : S_INSERT;
        else if (cur_q.op == slc_pkg::OP_TRIM)
          state_d = S_WALK;
        else
          state_d = S_ACK;
      end
      S_MOVE: begin
        shift_en  = 1'b1;
        is_move   = 1'b1;
        shift_lim = pos_q;
        state_d   = S_ACK;
      end
      S_FULLEV: begin
        if (out_free) begin
          emit    = 1'b1;
          n_d     = n_q - 1'b1;
          total_d = total_q - slc_pkg::TOT_W'(size_q[tail]);
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        shift_en = 1'b1;
        n_d      = n_q + 1'b1;
        total_d  = total_q + slc_pkg::TOT_W'(cur_q.size);
        state_d  = S_WALK;
      end
      S_WALK: begin
        if ((total_q > budget_i) && (n_q != '0) &&
            (evc_q < slc_pkg::EVC_W'(slc_pkg::MAX_EVICT))) begin
          if (out_free) begin
            emit    = 1'b1;
            n_d     = n_q - 1'b1;
            total_d = total_q - slc_pkg::TOT_W'(size_q[tail]);
          end
        end else begin
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          res_d.kind        = slc_pkg::KIND_ACK;
          res_d.out_key     = cur_q.key;
          res_d.hit         = hit_q;
          res_d.total_bytes = total_q;
          res_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit) begin
      res_d.kind        = slc_pkg::KIND_EVICT;
      res_d.out_key     = key_q[tail];
      res_d.hit         = 1'b0;
      res_d.total_bytes = total_d;
      res_d.last        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      total_q     <= total_d;
      res_valid_q <= (res_valid_q && !res_ready_i) || emit ||
                     (state_q == S_ACK && out_free);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && req_valid_i) begin
      cur_q <= req_i;
      evc_q <= '0;
      hit_q <= 1'b0;
    end
    if (state_q == S_SEARCH) begin
      pos_q <= match_pos;
      hit_q <= (|match) &&
               (cur_q.op == slc_pkg::OP_LOOKUP || cur_q.op == slc_pkg::OP_INSERT);
    end
    if (emit) evc_q <= evc_q + 1'b1;
    if (shift_en) begin
      for (int p = 1; p < ENTRIES; p++) begin
        if (IW'(p) <= shift_lim) begin
          key_q[p]  <= key_q[p-1];
          size_q[p] <= size_q[p-1];
        end
      end
      key_q[0]  <= cur_q.key;
      size_q[0] <= is_move ? size_q[pos_q] : cur_q.size;
    end
  end

endmodule

// ===== src/size_budget_lru_cache.sv =====
// Size-budget LRU cache: top level with budget register, front end, queue
// and back end. Depends on slc_pkg, slc_if, slc_front, slc_fifo, slc_back.
//
// Holds up to ENTRIES keyed entries in recency order, each with a byte size.
// Every request yields zero or more eviction items (oldest first) and then one
// acknowledgment with last set. An accepted input is dequeued, its key is
// searched over all cells in parallel, then a hit moves to front, a trim runs
// the budget check, a missed insert evicts if full, inserts and runs it, and a
// missed lookup or unused op code acks at once. Evictions come from the tail
// as the back end walks it, so the rate is set by the back end sequencer and
// by how quickly results are taken. The cfg channel is always ready; the user
// must write the size budget only while idle; the block does not enforce it.
module size_budget_lru_cache #(
  parameter int ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  slc_item_if.sink      in_i,
  slc_result_if.source  out_o,
  slc_cfg_if.sink       cfg_i
);

  logic [slc_pkg::TOT_W-1:0] budget_q;
  logic                      f_valid, f_ready, b_valid, b_ready;
  slc_pkg::req_t             f_req, b_req;
  slc_pkg::res_t             res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= slc_pkg::BUDGET_RESET;
    end else if (cfg_i.valid) begin
      budget_q <= cfg_i.data;
    end
  end

  slc_front u_front (
    .in_i      (in_i),
    .q_ready_i (f_ready),
    .q_valid_o (f_valid),
    .q_req_o   (f_req)
  );

  slc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_req_i   (f_req),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_req_o    (b_req)
  );

  slc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (b_valid),
    .req_ready_o (b_ready),
    .req_i       (b_req),
    .budget_i    (budget_q),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.kind        = res.kind;
  assign out_o.out_key     = res.out_key;
  assign out_o.hit         = res.hit;
  assign out_o.total_bytes = res.total_bytes;
  assign out_o.last        = res.last;

endmodule
